### design/ssr_pkg.sv
package ssr_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int OUT_CH       = 3;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W        = 16;
    localparam int PER_W        = 8;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [PER_W-1:0] PERIOD_RST = 8'd20;
    localparam logic [POS_W-1:0] HOME_RST [OUT_CH] = '{16'd2500, 16'd5500, 16'd1500};
    localparam logic [POS_W-1:0] STEP_RST = 16'd1;

    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_PERIOD      = 2'd0;
    localparam logic [1:0] REG_HOME_PUSH   = 2'd1;
    localparam logic [1:0] REG_HOME_BUCKET = 2'd2;
    localparam logic [1:0] REG_HOME_BOTTOM = 2'd3;

    typedef enum logic [1:0] {
        KIND_MOVE,
        KIND_TICK,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   ch;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  duration;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_DIV_S,
        ST_COMMIT
    } state_t;

    function automatic logic [POS_W-1:0] home_rst(input int c);
        home_rst = (c < OUT_CH) ? HOME_RST[c] : '0;
    endfunction

endpackage

### design/ssr_div.sv
module ssr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [15:0] quot_ceil
);
    import ssr_pkg::*;

    logic [POS_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] quo_reg, quo_next;
    logic [POS_W-1:0] dvs_reg, dvs_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [POS_W:0]   trial;
    logic [POS_W:0]   shifted;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[POS_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[POS_W])
                rem_next = trial[POS_W-1:0];
            else
                rem_next = shifted[POS_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], ~trial[POS_W]};
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quot_ceil = quo_reg + POS_W'(rem_reg != '0);

endmodule

### design/ssr_front.sv
module ssr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          op,
    input  logic [1:0]    channel,
    input  logic [15:0]   target,
    input  logic [15:0]   duration_ms,
    output logic          q_valid,
    output ssr_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import ssr_pkg::*;

    cmd_t              fifo_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              cmd_in;

    always_comb begin
        cmd_in.target   = target;
        cmd_in.duration = duration_ms;
        cmd_in.ch       = CH_W'(channel);
        if (op == OP_TICK)
            cmd_in.kind = KIND_TICK;
        else if (32'(channel) < NUM_CHANNELS)
            cmd_in.kind = KIND_MOVE;
        else
            cmd_in.kind = KIND_NOP;   // move to a channel that does not exist
    end

    assign in_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (q_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !q_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!push && q_pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

### design/ssr_back.sv
module ssr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ssr_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [15:0]   push_arm_pos,
    output logic [15:0]   bucket_arm_pos,
    output logic [15:0]   bucket_bottom_pos,
    output logic [2:0]    moving_mask,
    output logic [2:0]    written_mask,
    output logic          tick_running
);
    import ssr_pkg::*;

    state_t            state_reg, state_next;
    logic [PER_W-1:0]  period_reg, period_next;
    logic [POS_W-1:0]  home_reg [OUT_CH];
    logic [POS_W-1:0]  home_next [OUT_CH];
    logic [POS_W-1:0]  pos_reg  [NUM_CHANNELS];
    logic [POS_W-1:0]  pos_next [NUM_CHANNELS];
    logic [POS_W-1:0]  goal_reg [NUM_CHANNELS];
    logic [POS_W-1:0]  goal_next [NUM_CHANNELS];
    logic [POS_W-1:0]  step_reg [NUM_CHANNELS];
    logic [POS_W-1:0]  step_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] slew_reg, slew_next;

    logic [CH_W-1:0]   mv_ch_reg, mv_ch_next;
    logic [POS_W-1:0]  mv_tgt_reg, mv_tgt_next;
    logic [POS_W-1:0]  mv_dist_reg, mv_dist_next;
    logic [POS_W-1:0]  mv_step_reg, mv_step_next;

    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg [OUT_CH];
    logic [POS_W-1:0]  out_pos_next [OUT_CH];
    logic [OUT_CH-1:0] out_mov_reg, out_mov_next;
    logic [OUT_CH-1:0] out_wr_reg, out_wr_next;
    logic              out_run_reg;

    logic              out_free;
    logic              load_out;
    logic              div_start;
    logic [POS_W-1:0]  div_a;
    logic [POS_W-1:0]  div_b;
    logic              div_busy;
    logic              div_done;
    logic [POS_W-1:0]  div_q;
    logic [POS_W-1:0]  div_q_min1;
    logic [PER_W-1:0]  per_eff;
    logic [POS_W-1:0]  cur_pos;
    logic              home_we;
    logic [1:0]        home_ch;

    ssr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .done      (div_done),
        .quot_ceil (div_q)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign per_eff    = (period_reg == '0) ? PER_W'(1) : period_reg;
    assign div_q_min1 = (div_q == '0) ? POS_W'(1) : div_q;
    assign cur_pos    = pos_reg[q_cmd.ch];
    assign home_ch    = cfg_index - REG_HOME_PUSH;

    always_comb begin
        logic [POS_W:0]   sum;
        logic [POS_W-1:0] nx;

        state_next   = state_reg;
        period_next  = period_reg;
        home_next    = home_reg;
        pos_next     = pos_reg;
        goal_next    = goal_reg;
        step_next    = step_reg;
        slew_next    = slew_reg;
        mv_ch_next   = mv_ch_reg;
        mv_tgt_next  = mv_tgt_reg;
        mv_dist_next = mv_dist_reg;
        mv_step_next = mv_step_reg;
        out_wr_next  = '0;
        q_pop        = 1'b0;
        load_out     = 1'b0;
        div_start    = 1'b0;
        div_a        = q_cmd.duration;
        div_b        = {{(POS_W-PER_W){1'b0}}, per_eff};
        sum          = '0;
        nx           = '0;
        home_we      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        KIND_MOVE:
                        begin
                            // first pass: updates = ceil(duration / period)
                            q_pop        = 1'b1;
                            div_start    = 1'b1;
                            mv_ch_next   = q_cmd.ch;
                            mv_tgt_next  = q_cmd.target;
                            mv_dist_next = (cur_pos > q_cmd.target) ?
                                           cur_pos - q_cmd.target : q_cmd.target - cur_pos;
                            state_next   = ST_DIV_N;
                        end
                        KIND_TICK:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                load_out = 1'b1;
                                for (int c = 0; c < NUM_CHANNELS; c++)
                                begin
                                    if (slew_reg[c])
                                    begin
                                        if (pos_reg[c] == goal_reg[c])
                                            slew_next[c] = 1'b0;
                                        else
                                        begin
                                            if (pos_reg[c] < goal_reg[c])
                                            begin
                                                // 17-bit sum, no wrap past the top
                                                sum = {1'b0, pos_reg[c]} + {1'b0, step_reg[c]};
                                                nx  = (sum > {1'b0, goal_reg[c]}) ?
                                                      goal_reg[c] : sum[POS_W-1:0];
                                            end
                                            else
                                            begin
                                                nx = (pos_reg[c] > step_reg[c]) ?
                                                     pos_reg[c] - step_reg[c] : '0;
                                                if (nx < goal_reg[c])
                                                    nx = goal_reg[c];
                                            end
                                            pos_next[c] = nx;
                                            if (c < OUT_CH)
                                                out_wr_next[c] = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DIV_N:
            begin
                div_a = mv_dist_reg;
                div_b = div_q_min1;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                if (div_done)
                begin
                    mv_step_next = div_q_min1;
                    state_next   = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    load_out             = 1'b1;
                    goal_next[mv_ch_reg] = mv_tgt_reg;
                    step_next[mv_ch_reg] = mv_step_reg;
                    slew_next[mv_ch_reg] = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // config writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:
                    period_next = cfg_data[PER_W-1:0];
                REG_HOME_PUSH, REG_HOME_BUCKET, REG_HOME_BOTTOM:
                    home_we = 1'b1;
                default:
                    home_we = 1'b0;
            endcase
        end
        if (home_we)
        begin
            home_next[home_ch] = cfg_data;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (32'(home_ch) == c)
                begin
                    pos_next[c]  = cfg_data;
                    goal_next[c] = cfg_data;
                    slew_next[c] = 1'b0;
                end
            end
        end

        out_pos_next = '{default: '0};
        out_mov_next = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (c < OUT_CH)
            begin
                out_pos_next[c] = pos_next[c];
                out_mov_next[c] = slew_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RST;
            out_valid_reg <= 1'b0;
            slew_reg      <= '0;
            for (int c = 0; c < OUT_CH; c++)
                home_reg[c] <= HOME_RST[c];
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                pos_reg[c]  <= home_rst(c);
                goal_reg[c] <= home_rst(c);
                step_reg[c] <= STEP_RST;
            end
        end
        else
        begin
            state_reg  <= state_next;
            period_reg <= period_next;
            home_reg   <= home_next;
            pos_reg    <= pos_next;
            goal_reg   <= goal_next;
            step_reg   <= step_next;
            slew_reg   <= slew_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_ch_reg   <= mv_ch_next;
        mv_tgt_reg  <= mv_tgt_next;
        mv_dist_reg <= mv_dist_next;
        mv_step_reg <= mv_step_next;
        if (load_out)
        begin
            out_pos_reg <= out_pos_next;
            out_mov_reg <= out_mov_next;
            out_wr_reg  <= out_wr_next;
            out_run_reg <= |slew_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign push_arm_pos      = out_pos_reg[0];
    assign bucket_arm_pos    = out_pos_reg[1];
    assign bucket_bottom_pos = out_pos_reg[2];
    assign moving_mask       = out_mov_reg;
    assign written_mask      = out_wr_reg;
    assign tick_running      = out_run_reg;

    // words only leave the queue from idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue pop outside idle");

    // a channel written by a tick keeps slewing
    a_written_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (written_mask & ~moving_mask) == '0)
        else $error("written channel not marked moving");

    a_running_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (NUM_CHANNELS > OUT_CH) || (tick_running == |moving_mask))
        else $error("tick_running disagrees with moving_mask");

    // divider must finish before the next division is launched
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

### design/servo_slew_ramp_generator_top.sv
// Servo slew ramp generator: three position commands ramp toward their goals. A move word
// (op 0) loads one channel's goal and step size, ceil(distance / ceil(duration / period)),
// at least 1; a tick word (op 1) steps every slewing channel once toward its goal. Every
// word returns one result word with positions and flags after it. A tick, or a move to a
// channel that does not exist, is done from the head of the two-word input queue once the
// output is free; a move goes through the shared 16-step serial divider, which runs twice per
// move. Configuration writes must come only while the block is idle.
module servo_slew_ramp_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [1:0]  channel,
    input  logic [15:0] target,
    input  logic [15:0] duration_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] push_arm_pos,
    output logic [15:0] bucket_arm_pos,
    output logic [15:0] bucket_bottom_pos,
    output logic [2:0]  moving_mask,
    output logic [2:0]  written_mask,
    output logic        tick_running,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ssr_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    ssr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .channel     (channel),
        .target      (target),
        .duration_ms (duration_ms),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    ssr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_pop             (q_pop),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .push_arm_pos      (push_arm_pos),
        .bucket_arm_pos    (bucket_arm_pos),
        .bucket_bottom_pos (bucket_bottom_pos),
        .moving_mask       (moving_mask),
        .written_mask      (written_mask),
        .tick_running      (tick_running)
    );

endmodule

### test/servo_slew_ramp_generator_top_tb.sv
`timescale 1ns / 1ps

module servo_slew_ramp_generator_top_tb;
    import ssr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int WORDS_PER_PHASE = 125;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic [15:0] push;
        logic [15:0] bucket;
        logic [15:0] bottom;
        logic [2:0]  moving;
        logic [2:0]  written;
        logic        running;
    } ramp_t;

    typedef struct packed {
        logic        opw;
        logic [1:0]  chw;
        logic [15:0] tgt;
        logic [15:0] dur;
        logic        typed;
        ramp_t       res;
    } ramp_row_t;

    // reset config: period 20, homes 2500 / 5500 / 1500
    localparam ramp_row_t ROWS [18] = '{
        // idle tick, ignored fields at their extremes
        '{OP_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'd2500, 16'd5500, 16'd1500, 3'd0, 3'd0, 1'b0}},
        // move to a channel that does not exist
        '{OP_MOVE, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'd2500, 16'd5500, 16'd1500, 3'd0, 3'd0, 1'b0}},
        // zero duration: one step covers the whole distance
        '{OP_MOVE, 2'd0, 16'd2600, 16'd0, 1'b1,
          '{16'd2500, 16'd5500, 16'd1500, 3'd1, 3'd0, 1'b1}},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b1,
          '{16'd2600, 16'd5500, 16'd1500, 3'd1, 3'd1, 1'b1}},
        // at goal: stops without a write
        '{OP_TICK, 2'd1, 16'h5A5A, 16'hA5A5, 1'b1,
          '{16'd2600, 16'd5500, 16'd1500, 3'd0, 3'd0, 1'b0}},
        '{OP_MOVE, 2'd1, 16'd0, 16'd0, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_MOVE, 2'd2, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{OP_MOVE, 2'd0, 16'd0, 16'hFFFF, 1'b0, '0},
        '{OP_MOVE, 2'd1, 16'hFFFF, 16'd40, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        // second half step would pass the top, clamps at the goal
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        // full-range step down to zero
        '{OP_MOVE, 2'd1, 16'd0, 16'd20, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0},
        // zero distance: step of one, stops on the next tick
        '{OP_MOVE, 2'd1, 16'd0, 16'd100, 1'b0, '0},
        '{OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0, '0}
    };

    localparam logic [7:0] PERIODS [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd20,
                                                    8'd7, 8'd1, 8'd255, 8'd3};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_TICK;
    logic [1:0]  channel = '0;
    logic [15:0] target = '0;
    logic [15:0] duration_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] push_arm_pos;
    logic [15:0] bucket_arm_pos;
    logic [15:0] bucket_bottom_pos;
    logic [2:0]  moving_mask;
    logic [2:0]  written_mask;
    logic        tick_running;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [7:0]  per_ms;
    logic [15:0] cur_pos    [NUM_CHANNELS];
    logic [15:0] cur_goal   [NUM_CHANNELS];
    logic [15:0] cur_stride [NUM_CHANNELS];
    logic        cur_active [NUM_CHANNELS];

    ramp_t       ramp_q [$];
    logic        typed_now = 1'b0;
    ramp_t       typed_res = '0;
    int          mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet = 0;

    always #2 clk = ~clk;

    servo_slew_ramp_generator_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .channel           (channel),
        .target            (target),
        .duration_ms       (duration_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .push_arm_pos      (push_arm_pos),
        .bucket_arm_pos    (bucket_arm_pos),
        .bucket_bottom_pos (bucket_bottom_pos),
        .moving_mask       (moving_mask),
        .written_mask      (written_mask),
        .tick_running      (tick_running),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    function automatic ramp_t ramp_step(input logic opw, input logic [1:0] chw,
                                        input logic [15:0] tgt, input logic [15:0] dur);
        ramp_t       r;
        int          c;
        int unsigned per, n, span, s, p, g, nx;
        r = '0;
        if (opw == OP_MOVE)
        begin
            if (chw < NUM_CHANNELS)
            begin
                per = (per_ms == 0) ? 1 : int'(per_ms);
                n = (int'(dur) + per - 1) / per;
                if (n < 1)
                    n = 1;
                p = 32'(cur_pos[chw]);
                span = (p > 32'(tgt)) ? p - 32'(tgt) : 32'(tgt) - p;
                s = (span + n - 1) / n;
                if (s < 1)
                    s = 1;
                cur_goal[chw] = tgt;
                cur_stride[chw] = s[15:0];
                cur_active[chw] = 1'b1;
            end
        end
        else
        begin
            for (c = 0; c < NUM_CHANNELS; c++)
            begin
                p = 32'(cur_pos[c]);
                g = 32'(cur_goal[c]);
                s = 32'(cur_stride[c]);
                if (cur_active[c])
                begin
                    if (p == g)
                    begin
                        cur_active[c] = 1'b0;
                    end
                    else
                    begin
                        if (p < g)
                        begin
                            nx = p + s;         // no wrap at 16 bits
                            if (nx > g)
                                nx = g;
                        end
                        else
                        begin
                            nx = (p > s) ? p - s : 0;
                            if (nx < g)
                                nx = g;
                        end
                        cur_pos[c] = nx[15:0];
                        r.written[c] = 1'b1;
                    end
                end
            end
        end
        r.push = cur_pos[0];
        r.bucket = cur_pos[1];
        r.bottom = cur_pos[2];
        for (c = 0; c < NUM_CHANNELS; c++)
        begin
            r.moving[c] = cur_active[c];
            r.running |= cur_active[c];
        end
        return r;
    endfunction

    // called at a rising edge, returns at one
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        int c;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_PERIOD)
        begin
            per_ms = data[7:0];
        end
        else
        begin
            c = int'(idx) - 1;
            cur_pos[c] = data;
            cur_goal[c] = data;
            cur_active[c] = 1'b0;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic opw, input logic [1:0] chw, input logic [15:0] tgt,
                             input logic [15:0] dur, input logic typed, input ramp_t res);
        in_valid <= 1'b1;
        op <= opw;
        channel <= chw;
        target <= tgt;
        duration_ms <= dur;
        typed_now <= typed;
        typed_res <= res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ramp_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    // prediction at input acceptance
    always @(posedge clk)
    begin : predict_in
        ramp_t p;
        if (rst_n && in_valid && !in_stall)
        begin
            p = ramp_step(op, channel, target, duration_ms);
            ramp_q.push_back(typed_now ? typed_res : p);
        end
    end

    always @(posedge clk)
    begin : check_out
        ramp_t want;
        ramp_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{push_arm_pos, bucket_arm_pos, bucket_bottom_pos,
                    moving_mask, written_mask, tick_running};
            if (ramp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: pos %0d/%0d/%0d", got.push,
                             got.bucket, got.bottom);
            end
            else
            begin
                want = ramp_q.pop_front();
                if (got.push !== want.push || got.bucket !== want.bucket ||
                    got.bottom !== want.bottom || got.moving !== want.moving ||
                    got.written !== want.written || got.running !== want.running)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ramp mismatch: exp pos %0d/%0d/%0d mov %b wr %b run %b",
                                 want.push, want.bucket, want.bottom, want.moving,
                                 want.written, want.running);
                        $display("               got pos %0d/%0d/%0d mov %b wr %b run %b",
                                 got.push, got.bucket, got.bottom, got.moving,
                                 got.written, got.running);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("servo_slew_ramp_generator_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          i;
        int          ph;
        logic        opw;
        logic [1:0]  chw;
        logic [15:0] tgt;
        logic [15:0] dur;
        per_ms = PERIOD_RST;
        for (i = 0; i < NUM_CHANNELS; i++)
        begin
            cur_pos[i] = home_rst(i);
            cur_goal[i] = home_rst(i);
            cur_stride[i] = STEP_RST;
            cur_active[i] = 1'b0;
        end
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(ROWS); i++)
            send_word(ROWS[i].opw, ROWS[i].chw, ROWS[i].tgt, ROWS[i].dur,
                      ROWS[i].typed, ROWS[i].res);
        finish_phase();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(REG_PERIOD, {8'($urandom_range(0, 255)), PERIODS[ph]});
            // some phases keep homes so slews carry across a period change
            if (ph < 2 || ph % 2 == 0)
            begin
                write_reg(REG_HOME_PUSH, (ph == 0) ? 16'h0000 :
                          (ph == 1) ? 16'hFFFF : 16'($urandom));
                write_reg(REG_HOME_BUCKET, (ph == 0) ? 16'hFFFF :
                          (ph == 1) ? 16'h0000 : 16'($urandom));
                write_reg(REG_HOME_BOTTOM, (ph == 0) ? 16'h0000 :
                          (ph == 1) ? 16'hFFFF : 16'($urandom));
            end
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 20;
                    stall_pct = 20;
                end
            endcase
            // long output hold while words keep coming: input must back up
            if (ph == 0)
                hold_reqs++;
            for (i = 0; i < WORDS_PER_PHASE; i++)
            begin
                opw = ($urandom_range(0, 99) < 65) ? OP_TICK : OP_MOVE;
                chw = 2'($urandom_range(0, 3));
                if (opw == OP_MOVE && chw == 2'd3 && $urandom_range(0, 3) != 0)
                    chw = 2'($urandom_range(0, 2));
                case ($urandom_range(0, 7))
                    0: tgt = 16'h0000;
                    1: tgt = 16'hFFFF;
                    2: tgt = 16'($urandom_range(0, 255));
                    default: tgt = 16'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0: dur = 16'h0000;
                    1: dur = 16'hFFFF;
                    2: dur = 16'($urandom);
                    default: dur = 16'($urandom_range(0, 200));
                endcase
                send_word(opw, chw, tgt, dur, 1'b0, '0);
            end
            finish_phase();
        end

        repeat (50)
            @(posedge clk);
        if (mismatches == 0 && ramp_q.size() == 0)
            $display("servo_slew_ramp_generator_top_tb: PASS");
        else
            $display("servo_slew_ramp_generator_top_tb: FAIL");
        $finish;
    end

endmodule
